@@ sv/multiturn_angle_velocity_tracker_unit_macros.svh @@
// Assertion macros for the multiturn angle and velocity tracker.
// Used by the checker module; each macro expects a clock named clk in scope.
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_UNIT_MACROS_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MAVT_ASSERT_NOW(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("mavt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MAVT_ASSERT_NEXT(lbl, dis, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("mavt: next-cycle check failed");

`endif

@@ sv/mavt_pkg.sv @@
// Shared types and constants of the multiturn angle and velocity tracker.
// No dependencies; imported by every module of the block but the queue.
package mavt_pkg;

  localparam int TURN_W     = 20;
  localparam int POS_W      = 32;
  localparam int VEL_W      = 32;
  localparam int DMAG_W     = POS_W + 1;
  localparam int THR_W      = 12;
  localparam int RATE_W     = 26;
  localparam int MINT_W     = 24;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 26;

  // Product of position change and tick rate, and the divider split.
  localparam int PROD_W    = DMAG_W + RATE_W;
  localparam int Q_W       = VEL_W - 1;
  localparam int HI_W      = PROD_W - Q_W;
  localparam int MUL_LO_W  = 17;
  localparam int MUL_HI_W  = DMAG_W - MUL_LO_W;

  // Result stream layout.
  localparam int RES_W     = POS_W + TURN_W + VEL_W;
  localparam int OUT_TD_W  = ((RES_W + 7) / 8) * 8;
  localparam int VEL_LSB   = POS_W + TURN_W;

  localparam logic [THR_W-1:0]  THR_RST  = 12'd3276;
  localparam logic [RATE_W-1:0] RATE_RST = 26'd9000000;
  localparam logic [MINT_W-1:0] MINT_RST = 24'd900;

  localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
  localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};
  localparam logic signed [VEL_W-1:0]  INT_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0]  INT_MIN  = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_WRAP_THR  = 2'd0,
    CFG_TICK_RATE = 2'd1,
    CFG_MIN_TICKS = 2'd2
  } cfg_idx_t;

  // One classified sample handed from the front to the back.
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [TURN_W-1:0] turns;
    logic              too_short;
    logic              dneg;
    logic [DMAG_W-1:0] dmag;
  } job_t;

  // One finished result.
  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [TURN_W-1:0] turns;
    logic [VEL_W-1:0]  velocity;
    logic              too_short;
  } result_t;

endpackage

@@ sv/mavt_front.sv @@
// Front end: accepts samples, tracks turns, position and elapsed ticks.
// Depends on mavt_pkg; feeds classified jobs into the queue.
module mavt_front #(
  parameter int ANGLE_BITS = 12,
  parameter int TIMER_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ANGLE_BITS-1:0]         in_angle,
  input  logic [TIMER_BITS-1:0]         in_timer,
  input  logic [mavt_pkg::THR_W-1:0]    wrap_thr,
  input  logic [mavt_pkg::MINT_W-1:0]   min_ticks,
  output logic                          push_valid,
  input  logic                          push_ready,
  output mavt_pkg::job_t                push_job,
  output logic [TIMER_BITS-1:0]         push_elapsed
);
  import mavt_pkg::*;

  localparam int JW  = ANGLE_BITS + 1;
  localparam int CW  = (JW > THR_W) ? JW : THR_W;
  localparam int PW  = TURN_W + ANGLE_BITS;
  localparam int PWX = (PW > POS_W) ? PW : POS_W;
  localparam int EW  = (TIMER_BITS > MINT_W) ? TIMER_BITS : MINT_W;

  logic [ANGLE_BITS-1:0]      last_angle_r;
  logic signed [TURN_W-1:0]   turns_r;
  logic [TIMER_BITS-1:0]      last_timer_r;
  logic [POS_W-1:0]           last_pos_r;
  logic                       s1_valid_r;
  logic [POS_W-1:0]           s1_pos_r;
  logic [TURN_W-1:0]          s1_turns_r;
  logic [TIMER_BITS-1:0]      s1_elapsed_r;
  logic                       s1_short_r;

  logic signed [JW-1:0]       jump;
  logic [JW-1:0]              jump_mag;
  logic                       crossing;
  logic signed [TURN_W-1:0]   turns_nxt;
  logic signed [PWX-1:0]      pos_x;
  logic [POS_W-1:0]           pos_nxt;
  logic [TIMER_BITS-1:0]      elapsed_nxt;
  logic                       short_nxt;
  logic                       accept;
  logic                       push;
  logic signed [DMAG_W-1:0]   dpos;

  assign accept = in_valid && in_ready;
  assign push   = s1_valid_r && push_ready;
  assign in_ready = !s1_valid_r || push_ready;

  // Turn crossing: a jump larger than the threshold moves the turn count.
  assign jump     = $signed({1'b0, in_angle}) - $signed({1'b0, last_angle_r});
  assign jump_mag = jump[JW-1] ? unsigned'(-jump) : unsigned'(jump);
  assign crossing = CW'(jump_mag) > CW'(wrap_thr);

  always_comb begin
    turns_nxt = turns_r;
    if (crossing) begin
      if (!jump[JW-1]) begin
        if (turns_r != TURN_MIN) turns_nxt = turns_r - TURN_W'(1);
      end else begin
        if (turns_r != TURN_MAX) turns_nxt = turns_r + TURN_W'(1);
      end
    end
  end

  // Position is the turn count above the angle bits, clamped to 32 bits.
  assign pos_x = PWX'($signed({turns_nxt, in_angle}));

  always_comb begin
    if (pos_x > PWX'(INT_MAX)) begin
      pos_nxt = INT_MAX;
    end else if (pos_x < PWX'(INT_MIN)) begin
      pos_nxt = INT_MIN;
    end else begin
      pos_nxt = pos_x[POS_W-1:0];
    end
  end

  // Elapsed ticks of the down-counter; an equal or higher value means it wrapped.
  assign elapsed_nxt = (in_timer < last_timer_r) ? last_timer_r - in_timer
                                                 : last_timer_r + ~in_timer;
  assign short_nxt   = (elapsed_nxt == '0) || (EW'(elapsed_nxt) < EW'(min_ticks));

  // Position change against the previous pushed sample.
  assign dpos = $signed({s1_pos_r[POS_W-1], s1_pos_r})
              - $signed({last_pos_r[POS_W-1], last_pos_r});

  always_comb begin
    push_job.position  = s1_pos_r;
    push_job.turns     = s1_turns_r;
    push_job.too_short = s1_short_r;
    push_job.dneg      = dpos[DMAG_W-1];
    push_job.dmag      = dpos[DMAG_W-1] ? unsigned'(-dpos) : unsigned'(dpos);
  end

  assign push_valid   = s1_valid_r;
  assign push_elapsed = s1_elapsed_r;

  // Tracking state and the staging register between accept and push.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_angle_r <= '0;
      turns_r      <= '0;
      last_timer_r <= '0;
      last_pos_r   <= '0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (push) begin
        last_pos_r <= s1_pos_r;
      end
      if (accept) begin
        last_angle_r <= in_angle;
        turns_r      <= turns_nxt;
        last_timer_r <= in_timer;
        s1_valid_r   <= 1'b1;
      end else if (push) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pos_r     <= pos_nxt;
      s1_turns_r   <= turns_nxt;
      s1_elapsed_r <= elapsed_nxt;
      s1_short_r   <= short_nxt;
    end
  end

endmodule

@@ sv/mavt_queue.sv @@
// Two-entry queue between the front end and the velocity back end.
// Depends on nothing; width set by parameter.
module mavt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= !wr_ptr_r;
      if (do_rd) rd_ptr_r <= !rd_ptr_r;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

@@ sv/mavt_back.sv @@
// Back end: multiplies position change by tick rate, divides by elapsed ticks.
// Depends on mavt_pkg; holds the result register of the output stream.
module mavt_back #(
  parameter int TIMER_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         job_valid,
  output logic                         job_ready,
  input  mavt_pkg::job_t               job,
  input  logic [TIMER_BITS-1:0]        job_elapsed,
  input  logic [mavt_pkg::RATE_W-1:0]  tick_rate,
  output logic                         out_valid,
  input  logic                         out_ready,
  output mavt_pkg::result_t            out_res
);
  import mavt_pkg::*;

  localparam int CW    = (HI_W > TIMER_BITS) ? HI_W : TIMER_BITS;
  localparam int CNT_W = $clog2(Q_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(Q_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                       state_r;
  job_t                         job_r;
  logic [TIMER_BITS-1:0]        div_r;
  logic [PROD_W-1:0]            prod_r;
  logic [TIMER_BITS-1:0]        rem_r;
  logic [Q_W-1:0]               low_r;
  logic [Q_W-1:0]               q_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [VEL_W-1:0]             vel_r;
  logic                         out_valid_r;
  result_t                      out_res_r;

  logic [MUL_LO_W+RATE_W-1:0]   mul_lo;
  logic [MUL_HI_W+RATE_W-1:0]   mul_hi;
  logic [CW-1:0]                hi_ext;
  logic                         sat;
  logic [TIMER_BITS:0]          trial;
  logic                         take;
  logic [TIMER_BITS:0]          rem_nxt;
  logic [Q_W-1:0]               q_nxt;
  logic [VEL_W-1:0]             vel_div;
  logic                         load_out;

  assign job_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // A finished result moves into the output register once that is free.
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // Partial products of the 33 x 26 bit multiplication, one per cycle.
  assign mul_lo = job_r.dmag[MUL_LO_W-1:0] * tick_rate;
  assign mul_hi = job_r.dmag[DMAG_W-1:MUL_LO_W] * tick_rate;

  // A quotient of 2^31 or more shows in the upper product bits alone.
  assign hi_ext = CW'(prod_r[PROD_W-1:Q_W]);
  assign sat    = hi_ext >= CW'(div_r);

  // One restoring division step per cycle.
  assign trial   = {rem_r, low_r[Q_W-1]};
  assign take    = trial >= {1'b0, div_r};
  assign rem_nxt = take ? trial - {1'b0, div_r} : trial;
  assign q_nxt   = {q_r[Q_W-2:0], take};
  assign vel_div = job_r.dneg ? VEL_W'(-{1'b0, q_nxt}) : {1'b0, q_nxt};

  // Sequencer, datapath registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Result valid: set by a new result, cleared when the held one is taken.
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (job_valid) begin
            job_r <= job;
            div_r <= job_elapsed;
            if (job.too_short) begin
              vel_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MUL_LO;
            end
          end
        end
        ST_MUL_LO: begin
          prod_r  <= PROD_W'(mul_lo);
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          prod_r  <= prod_r + (PROD_W'(mul_hi) << MUL_LO_W);
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (sat) begin
            vel_r   <= job_r.dneg ? INT_MIN : INT_MAX;
            state_r <= ST_DONE;
          end else begin
            rem_r   <= hi_ext[TIMER_BITS-1:0];
            low_r   <= prod_r[Q_W-1:0];
            q_r     <= '0;
            cnt_r   <= CNT_LAST;
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt[TIMER_BITS-1:0];
          low_r <= {low_r[Q_W-2:0], 1'b0};
          q_r   <= q_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            vel_r   <= vel_div;
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_res_r.position  <= job_r.position;
            out_res_r.turns     <= job_r.turns;
            out_res_r.velocity  <= vel_r;
            out_res_r.too_short <= job_r.too_short;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/multiturn_angle_velocity_tracker_unit.sv @@
// The front staging register and the queue pass each sample to the back end, which
// sends a short interval straight to the result register, else multiplies, checks
// the range and divides unless the velocity saturates. It serves one sample at a
// time: two multiply steps, a range check, a 31-step one-bit-per-cycle divider.
// The front end and a two-entry queue take new samples while the divider runs.
// Reset (rst_n low, synchronous) clears tracking state and loads register defaults.
module multiturn_angle_velocity_tracker_unit #(
  parameter int ANGLE_BITS = 12,
  parameter int TIMER_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata: raw_angle, timer_value (from bit 0 up), zero padded
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((ANGLE_BITS+TIMER_BITS+7)/8)*8-1:0] in_tdata,
  // out_tdata: position, turn_count, velocity (from bit 0 up), zero padded
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mavt_pkg::OUT_TD_W-1:0]        out_tdata,
  // out_tuser: interval_too_short
  output logic                                 out_tuser,
  input  logic                                 cfg_we,
  input  logic [mavt_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [mavt_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import mavt_pkg::*;

  localparam int JOB_W = $bits(job_t) + TIMER_BITS;

  logic [THR_W-1:0]      wrap_thr_r;
  logic [RATE_W-1:0]     tick_rate_r;
  logic [MINT_W-1:0]     min_ticks_r;

  logic                  push_valid;
  logic                  push_ready;
  job_t                  push_job;
  logic [TIMER_BITS-1:0] push_elapsed;
  logic                  pop_valid;
  logic                  pop_ready;
  logic [JOB_W-1:0]      pop_data;
  job_t                  pop_job;
  logic [TIMER_BITS-1:0] pop_elapsed;
  result_t               res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_thr_r  <= THR_RST;
      tick_rate_r <= RATE_RST;
      min_ticks_r <= MINT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_WRAP_THR:  wrap_thr_r  <= cfg_wdata[THR_W-1:0];
        CFG_TICK_RATE: tick_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_MIN_TICKS: min_ticks_r <= cfg_wdata[MINT_W-1:0];
        default: ;
      endcase
    end
  end

  mavt_front #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_angle     (in_tdata[ANGLE_BITS-1:0]),
    .in_timer     (in_tdata[ANGLE_BITS+TIMER_BITS-1:ANGLE_BITS]),
    .wrap_thr     (wrap_thr_r),
    .min_ticks    (min_ticks_r),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_job     (push_job),
    .push_elapsed (push_elapsed)
  );

  mavt_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_job, push_elapsed}),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (pop_data)
  );

  assign pop_job     = pop_data[JOB_W-1:TIMER_BITS];
  assign pop_elapsed = pop_data[TIMER_BITS-1:0];

  mavt_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .job_valid   (pop_valid),
    .job_ready   (pop_ready),
    .job         (pop_job),
    .job_elapsed (pop_elapsed),
    .tick_rate   (tick_rate_r),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_res     (res)
  );

  // Result packing, position in the lowest bits.
  assign out_tdata = OUT_TD_W'({res.velocity, res.turns, res.position});
  assign out_tuser = res.too_short;

endmodule

@@ sv/mavt_checker.sv @@
// Port-level checks of the multiturn angle and velocity tracker.
// Depends on mavt_pkg and the assertion macro header; bound to the top level.
`include "multiturn_angle_velocity_tracker_unit_macros.svh"

module mavt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [mavt_pkg::OUT_TD_W-1:0] out_tdata,
  input logic                          out_tuser
);
  import mavt_pkg::*;

  // A stalled result keeps its value until it is taken.
  `MAVT_ASSERT_NEXT(a_out_hold, !rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // A short interval always reports zero velocity.
  `MAVT_ASSERT_NOW(a_short_zero_vel, !rst_n, out_tvalid && out_tuser, out_tdata[VEL_LSB+VEL_W-1:VEL_LSB] == '0)

  // Reset leaves no result pending.
  `MAVT_ASSERT_NEXT(a_reset_empty, 1'b0, !rst_n, !out_tvalid)

  // Padding bits above the velocity stay zero.
  `MAVT_ASSERT_NOW(a_pad_zero, !rst_n, out_tvalid, out_tdata[OUT_TD_W-1:RES_W] == '0)

endmodule

bind multiturn_angle_velocity_tracker_unit mavt_checker u_mavt_checker (.*);
